// ===== rtl/slint_pkg.sv =====
// Shared types, field widths and command codes for the sorted list intersection block.
package slint_pkg;

  localparam int LIST_DEPTH_DEF    = 32;
  localparam int MAX_ELEMENT_ITEMS = 32;
  localparam int ELEM_W            = 32;
  localparam int CMD_W             = 2;
  localparam int COUNT_W           = 6;

  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ELEM_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [ELEM_W-1:0]  element;
    logic               is_end;
    logic [COUNT_W-1:0] common_count;
    logic               any_common;
    logic               overflow;
  } result_t;

endpackage

// ===== rtl/slint_list_mem.sv =====
// One list store: single write port, single registered read port.
module slint_list_mem #(
  parameter int DEPTH = slint_pkg::LIST_DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [slint_pkg::ELEM_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [slint_pkg::ELEM_W-1:0] rd_data
);
  import slint_pkg::*;

  logic [ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/slint_seq.sv =====
// Sequencer: list lengths, load handling, two-pointer merge walk and result register.
module slint_seq #(
  parameter int LIST_DEPTH = slint_pkg::LIST_DEPTH_DEF,
  parameter int AW         = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  slint_pkg::item_t             item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output slint_pkg::result_t           result,
  output logic                         wr_a_en,
  output logic                         wr_b_en,
  output logic [AW-1:0]                wr_addr,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_addr_a,
  output logic [AW-1:0]                rd_addr_b,
  input  logic [slint_pkg::ELEM_W-1:0] rd_data_a,
  input  logic [slint_pkg::ELEM_W-1:0] rd_data_b
);
  import slint_pkg::*;

  localparam int LW = $clog2(LIST_DEPTH + 1);
  localparam logic [LW-1:0]      DEPTH_L = LW'(LIST_DEPTH);
  localparam logic [COUNT_W-1:0] EMIT_L  = COUNT_W'(MAX_ELEMENT_ITEMS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_END  = 4'b1000
  } state_t;

  state_t             state;
  logic [LW-1:0]      len_a, len_b, idx_a, idx_b;
  logic [COUNT_W-1:0] count;
  logic               dropped;
  logic               slot, walk_on, take;
  logic               result_load;

  assign slot       = !result_valid || result_ready;
  assign walk_on    = (idx_a < len_a) && (idx_b < len_b);
  assign take       = item_valid && item_ready;
  assign item_ready = (state == S_IDLE);

  // a new transaction enters the output register: an emitted match or the end summary
  assign result_load = ((state == S_CMP) && (rd_data_a == rd_data_b) && slot &&
                        (count < EMIT_L)) ||
                       ((state == S_END) && slot);

  assign wr_a_en   = take && (item.cmd == CMD_LOAD_A) && (len_a < DEPTH_L);
  assign wr_b_en   = take && (item.cmd == CMD_LOAD_B) && (len_b < DEPTH_L);
  assign wr_addr   = (item.cmd == CMD_LOAD_A) ? len_a[AW-1:0] : len_b[AW-1:0];
  assign rd_en     = (state == S_READ) && walk_on;
  assign rd_addr_a = idx_a[AW-1:0];
  assign rd_addr_b = idx_b[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      len_a        <= '0;
      len_b        <= '0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            case (item.cmd)
              CMD_LOAD_A: begin
                if (len_a < DEPTH_L) len_a <= len_a + LW'(1);
                else dropped <= 1'b1;
              end
              CMD_LOAD_B: begin
                if (len_b < DEPTH_L) len_b <= len_b + LW'(1);
                else dropped <= 1'b1;
              end
              CMD_RUN: begin
                idx_a <= '0;
                idx_b <= '0;
                count <= '0;
                state <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          state <= walk_on ? S_CMP : S_END;
        end
        S_CMP: begin
          if (rd_data_a == rd_data_b) begin
            // past the item cap the match is only counted
            if (count >= EMIT_L || slot) begin
              if (count < EMIT_L) begin
                result.element      <= rd_data_a;
                result.is_end       <= 1'b0;
                result.common_count <= '0;
                result.any_common   <= 1'b0;
                result.overflow     <= 1'b0;
              end
              count <= count + COUNT_W'(1);
              idx_a <= idx_a + LW'(1);
              idx_b <= idx_b + LW'(1);
              state <= S_READ;
            end
          end else if (rd_data_a < rd_data_b) begin
            idx_a <= idx_a + LW'(1);
            state <= S_READ;
          end else begin
            idx_b <= idx_b + LW'(1);
            state <= S_READ;
          end
        end
        S_END: begin
          if (slot) begin
            result.element      <= '0;
            result.is_end       <= 1'b1;
            result.common_count <= count;
            result.any_common   <= (count != '0);
            result.overflow     <= dropped;
            len_a               <= '0;
            len_b               <= '0;
            dropped             <= 1'b0;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (len_a <= DEPTH_L) && (len_b <= DEPTH_L))
    else $error("list length beyond depth");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (idx_a < len_a) && (idx_b < len_b))
    else $error("merge read past list end");

  a_emit_equal: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP && slot && rd_data_a == rd_data_b && count < EMIT_L)
      |=> result_valid && !result.is_end && result.element == $past(rd_data_a))
    else $error("element transaction lost or wrong");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_END && slot)
      |=> len_a == '0 && len_b == '0 && !dropped && result.is_end && state == S_IDLE)
    else $error("lists not emptied after end transaction");

endmodule

// ===== rtl/sorted_list_intersection_top.sv =====
// Top level of the sorted list intersection block: two list stores and the merge sequencer.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------------
//  item    | in        | item_valid / item_ready     | cmd, value (slint_pkg::item_t)
//  result  | out       | result_valid / result_ready | element, is_end, common_count,
//          |           |                            | any_common, overflow (result_t)
//
// A load transaction (cmd 0 or 1) or an unknown command is taken while idle and leaves the block idle.
// A run transaction walks both lists in merge steps, each a memory read (S_READ)
// then a compare (S_CMP), as the single registered read port of each list store
// feeds the one comparator; item_ready is low meanwhile.
// Each result sits in one output register; a stalled result_ready holds the
// walk at its next emitted match (below the item cap) or at the end transaction.
// Synchronous reset empties both lists and clears the overflow flag; the
// stores themselves are not cleared, only entries below the length are read.
module sorted_list_intersection_top #(
  parameter int LIST_DEPTH = slint_pkg::LIST_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  slint_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output slint_pkg::result_t result
);
  import slint_pkg::*;

  // address width of one list store
  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic              wr_a_en, wr_b_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
  logic [ELEM_W-1:0] rd_data_a, rd_data_b;

  // list A store: appended on cmd 0, read by the A pointer of the walk
  slint_list_mem #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_mem_a (
    .clk     (clk),
    .wr_en   (wr_a_en),
    .wr_addr (wr_addr),
    .wr_data (item.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_a),
    .rd_data (rd_data_a)
  );

  // list B store: appended on cmd 1, read by the B pointer of the walk
  slint_list_mem #(
    .DEPTH (LIST_DEPTH),
    .AW    (AW)
  ) u_mem_b (
    .clk     (clk),
    .wr_en   (wr_b_en),
    .wr_addr (wr_addr),
    .wr_data (item.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_b),
    .rd_data (rd_data_b)
  );

  // sequencer: lengths, overflow flag, merge walk and the result register
  slint_seq #(
    .LIST_DEPTH (LIST_DEPTH),
    .AW         (AW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .wr_a_en      (wr_a_en),
    .wr_b_en      (wr_b_en),
    .wr_addr      (wr_addr),
    .rd_en        (rd_en),
    .rd_addr_a    (rd_addr_a),
    .rd_addr_b    (rd_addr_b),
    .rd_data_a    (rd_data_a),
    .rd_data_b    (rd_data_b)
  );

endmodule
